### sv/md_message_padder_top_defines.svh
// assertion macros for the message padder
`ifndef MD_MESSAGE_PADDER_TOP_DEFINES_SVH
`define MD_MESSAGE_PADDER_TOP_DEFINES_SVH

// checked outside reset
`define MD_PAD_CHK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked through reset as well
`define MD_PAD_CHK_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### sv/md_pad_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package md_pad_pkg;

   localparam int MAX_BLOCK_WORDS  = 32;
   localparam int MAX_LENGTH_WORDS = 4;
   localparam int WORD_BITS        = 32;
   localparam int BYTE_BITS        = 8;

   localparam logic [1:0] CSR_BIG_ENDIAN   = 2'd0;
   localparam logic [1:0] CSR_BLOCK_WORDS  = 2'd1;
   localparam logic [1:0] CSR_LENGTH_WORDS = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_ZERO = 3'b010,
      ST_LEN  = 3'b100
   } state_type;

   typedef struct packed {
      logic inc;
      logic clr;
   } len_ctrl_type;

   function automatic logic [5:0] eff_block_words(input logic [5:0] b);
      logic [5:0] r;
      r = b;
      if (b < 6'd16) r = 6'd16;
      else if (b > 6'(MAX_BLOCK_WORDS)) r = 6'(MAX_BLOCK_WORDS);
      return r;
   endfunction

   function automatic logic [2:0] eff_length_words(input logic [2:0] l);
      logic [2:0] r;
      r = l;
      if (l < 3'd2) r = 3'd2;
      else if (l > 3'(MAX_LENGTH_WORDS)) r = 3'(MAX_LENGTH_WORDS);
      return r;
   endfunction

   function automatic logic [WORD_BITS-1:0] order_word(input logic be,
                                                       input logic [WORD_BITS-1:0] seq);
      logic [WORD_BITS-1:0] r;
      r = seq;
      if (!be) r = {seq[7:0], seq[15:8], seq[23:16], seq[31:24]};
      return r;
   endfunction

endpackage

`default_nettype wire

### sv/md_message_padder_top.sv
// channel  | ports                                   | dir
// req      | req_valid req_ready req_data_byte ...   | in
// rsp      | rsp_valid rsp_ready rsp_word ...        | out
// csr      | csr_wr_en csr_index csr_wdata           | in
//
// a byte item is taken only in idle; every fourth byte loads one word into the output register
// an end item loads one word a cycle: pad word, zero words, then the length words,
// up to the block end, while the output side takes each word
// the position counter and the output register set that pace; no new item meanwhile
// synchronous reset clears the sequencer, the packer and the length counter
// a stalled rsp channel holds the output register and stops req_ready
`timescale 1ns / 1ps
`default_nettype none

module md_message_padder_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_message_end,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_word,
   output logic [4:0]       rsp_word_index,
   output logic             rsp_block_end,
   output logic             rsp_padded_end,
   output logic             rsp_last_in_run,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [5:0]  csr_wdata
);

   logic       big_endian_ff;
   logic [5:0] block_words_ff;
   logic [2:0] length_words_ff;
   logic [5:0] bw_eff;
   logic [2:0] lw_eff;
   logic [1:0] len_sel;
   logic [31:0] len_word;
   md_pad_pkg::len_ctrl_type len_ctrl;

   always_ff @(posedge clock) begin
      if (reset) begin
         big_endian_ff   <= 1'b1;
         block_words_ff  <= 6'd16;
         length_words_ff <= 3'd2;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            md_pad_pkg::CSR_BIG_ENDIAN:   big_endian_ff   <= csr_wdata[0];
            md_pad_pkg::CSR_BLOCK_WORDS:  block_words_ff  <= csr_wdata;
            md_pad_pkg::CSR_LENGTH_WORDS: length_words_ff <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   assign bw_eff = md_pad_pkg::eff_block_words(block_words_ff);
   assign lw_eff = md_pad_pkg::eff_length_words(length_words_ff);

   md_pad_len u_len (
      .clock    (clock),
      .reset    (reset),
      .len_ctrl (len_ctrl),
      .lw_eff   (lw_eff),
      .len_sel  (len_sel),
      .len_word (len_word)
   );

   md_pad_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_message_end (req_message_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_word        (rsp_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_block_end   (rsp_block_end),
      .rsp_padded_end  (rsp_padded_end),
      .rsp_last_in_run (rsp_last_in_run),
      .big_endian      (big_endian_ff),
      .bw_eff          (bw_eff),
      .lw_eff          (lw_eff),
      .len_word        (len_word),
      .len_ctrl        (len_ctrl),
      .len_sel         (len_sel)
   );

endmodule

`default_nettype wire

### sv/md_pad_len.sv
`timescale 1ns / 1ps
`default_nettype none

module md_pad_len (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire md_pad_pkg::len_ctrl_type  len_ctrl,
   input  wire logic [2:0]                lw_eff,
   input  wire logic [1:0]                len_sel,
   output logic [md_pad_pkg::WORD_BITS-1:0] len_word
);

   // low half kept in bytes: its three low bits are always zero
   logic [60:0] lo_ff, lo_in;
   logic [63:0] hi_ff, hi_in, hi_sum;
   logic        carry;

   always_comb begin
      lo_in  = lo_ff;
      hi_in  = hi_ff;
      carry  = &lo_ff;
      hi_sum = hi_ff + 64'(carry);
      if (len_ctrl.clr) begin
         lo_in = '0;
         hi_in = '0;
      end else if (len_ctrl.inc) begin
         lo_in = lo_ff + 61'd1;
         if (lw_eff <= 3'd2) hi_in = '0;
         else if (lw_eff == 3'd3) hi_in = {32'd0, hi_sum[31:0]};
         else hi_in = hi_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ff <= '0;
         hi_ff <= '0;
      end else begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

   always_comb begin
      case (len_sel)
         2'd0:    len_word = {lo_ff[28:0], 3'b000};
         2'd1:    len_word = lo_ff[60:29];
         2'd2:    len_word = hi_ff[31:0];
         default: len_word = hi_ff[63:32];
      endcase
   end

endmodule

`default_nettype wire

### sv/md_pad_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module md_pad_seq (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [7:0]                  req_data_byte,
   input  wire logic                        req_message_end,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [md_pad_pkg::WORD_BITS-1:0] rsp_word,
   output logic [4:0]                       rsp_word_index,
   output logic                             rsp_block_end,
   output logic                             rsp_padded_end,
   output logic                             rsp_last_in_run,
   input  wire logic                        big_endian,
   input  wire logic [5:0]                  bw_eff,
   input  wire logic [2:0]                  lw_eff,
   input  wire logic [md_pad_pkg::WORD_BITS-1:0] len_word,
   output md_pad_pkg::len_ctrl_type         len_ctrl,
   output logic [1:0]                       len_sel
);

   md_pad_pkg::state_type state_ff, state_in;
   logic [23:0] partial_ff, partial_in;
   logic [1:0]  bcnt_ff, bcnt_in;
   logic [4:0]  wib_ff, wib_in, wib_next;
   logic [1:0]  k_ff, k_in;
   logic        rsp_valid_ff;
   logic [md_pad_pkg::WORD_BITS-1:0] word_ff, emit_word, pad_seq;
   logic [4:0]  index_ff;
   logic        bend_ff, pend_ff, last_ff;
   logic        out_free, accept, emit, emit_pend, emit_last, bend, at_target, k_last;
   logic [5:0]  target;
   logic [4:0]  pad_shift;
   logic [2:0]  sel_rev;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == md_pad_pkg::ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   assign bend      = (({1'b0, wib_ff} + 6'd1) >= bw_eff);
   assign wib_next  = bend ? 5'd0 : (wib_ff + 5'd1);
   assign target    = bw_eff - {3'd0, lw_eff};
   assign at_target = ({1'b0, wib_next} == target);
   assign pad_shift = {2'd3 - bcnt_ff, 3'b000};
   assign pad_seq   = {partial_ff, 8'h80} << pad_shift;
   assign k_last    = ({1'b0, k_ff} == (lw_eff - 3'd1));
   assign sel_rev   = lw_eff - 3'd1 - {1'b0, k_ff};
   assign len_sel   = big_endian ? sel_rev[1:0] : k_ff;

   always_comb begin
      state_in   = state_ff;
      partial_in = partial_ff;
      bcnt_in    = bcnt_ff;
      k_in       = k_ff;
      emit       = 1'b0;
      emit_word  = '0;
      emit_pend  = 1'b0;
      emit_last  = 1'b0;
      len_ctrl   = '0;
      unique case (state_ff)
         md_pad_pkg::ST_IDLE: begin
            if (accept && !req_message_end) begin
               len_ctrl.inc = 1'b1;
               if (bcnt_ff == 2'd3) begin
                  emit       = 1'b1;
                  emit_last  = 1'b1;
                  emit_word  = md_pad_pkg::order_word(big_endian,
                                                      {partial_ff, req_data_byte});
                  partial_in = '0;
                  bcnt_in    = 2'd0;
               end else begin
                  partial_in = {partial_ff[15:0], req_data_byte};
                  bcnt_in    = bcnt_ff + 2'd1;
               end
            end else if (accept) begin
               emit       = 1'b1;
               emit_word  = md_pad_pkg::order_word(big_endian, pad_seq);
               partial_in = '0;
               bcnt_in    = 2'd0;
               k_in       = 2'd0;
               state_in   = at_target ? md_pad_pkg::ST_LEN : md_pad_pkg::ST_ZERO;
            end
         end
         md_pad_pkg::ST_ZERO: begin
            if (out_free) begin
               emit = 1'b1;
               if (at_target) state_in = md_pad_pkg::ST_LEN;
            end
         end
         md_pad_pkg::ST_LEN: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_word = len_word;
               k_in      = k_ff + 2'd1;
               if (k_last) begin
                  emit_pend    = 1'b1;
                  emit_last    = 1'b1;
                  len_ctrl.clr = 1'b1;
                  state_in     = md_pad_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = md_pad_pkg::ST_IDLE;
      endcase
      wib_in = emit ? wib_next : wib_ff;
      if (emit_pend) wib_in = 5'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= md_pad_pkg::ST_IDLE;
         partial_ff   <= '0;
         bcnt_ff      <= '0;
         wib_ff       <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         partial_ff <= partial_in;
         bcnt_ff    <= bcnt_in;
         wib_ff     <= wib_in;
         k_ff       <= k_in;
         if (emit) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (emit) begin
         word_ff  <= emit_word;
         index_ff <= wib_ff;
         bend_ff  <= bend;
         pend_ff  <= emit_pend;
         last_ff  <= emit_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_word        = word_ff;
   assign rsp_word_index  = index_ff;
   assign rsp_block_end   = bend_ff;
   assign rsp_padded_end  = pend_ff;
   assign rsp_last_in_run = last_ff;

endmodule

`default_nettype wire

### sv/md_pad_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "md_message_padder_top_defines.svh"

module md_pad_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_message_end,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_word,
   input wire logic [4:0]  rsp_word_index,
   input wire logic        rsp_block_end,
   input wire logic        rsp_padded_end,
   input wire logic        rsp_last_in_run
);

   `MD_PAD_CHK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word) && $stable(rsp_word_index), "rsp item changed while stalled")
   `MD_PAD_CHK(a_busy_after_end, req_valid && req_ready && req_message_end |=> !req_ready, "item taken during padding flush")
   `MD_PAD_CHK(a_pad_end_flags, rsp_valid && rsp_padded_end |-> rsp_block_end && rsp_last_in_run, "padded end not on block end")
   `MD_PAD_CHK(a_block_end_pos, rsp_valid && rsp_block_end |-> rsp_word_index >= 5'd15, "block ended too early")
   `MD_PAD_CHK_RST(a_reset_empty, reset |=> !rsp_valid, "rsp valid after reset")

endmodule

bind md_message_padder_top md_pad_checker u_md_pad_checker (.*);

`default_nettype wire

### test/md_message_padder_top_tb.sv
`timescale 1ns / 1ps

typedef struct packed {
   logic [31:0] word;
   logic [4:0]  word_index;
   logic        block_end;
   logic        padded_end;
   logic        last_in_run;
} pad_word_type;

class md_pad_scoreboard;
   bit        big_end;
   bit [5:0]  blk_raw;
   bit [2:0]  len_raw;
   bit [23:0] held;
   bit [1:0]  held_cnt;
   bit [4:0]  pos;
   bit [63:0] bits_lo;
   bit [63:0] bits_hi;
   pad_word_type pending_words[$];
   int        errors;
   int        words_checked;

   function new();
      big_end = 1'b1;
      blk_raw = 6'd16;
      len_raw = 3'd2;
      errors = 0;
      words_checked = 0;
      clear_message();
   endfunction

   function void clear_message();
      held = '0;
      held_cnt = '0;
      pos = '0;
      bits_lo = '0;
      bits_hi = '0;
   endfunction

   function void write_reg(logic [1:0] idx, logic [5:0] val);
      case (idx)
         md_pad_pkg::CSR_BIG_ENDIAN:   big_end = val[0];
         md_pad_pkg::CSR_BLOCK_WORDS:  blk_raw = val;
         md_pad_pkg::CSR_LENGTH_WORDS: len_raw = val[2:0];
         default: ;
      endcase
   endfunction

   function int blk();
      if (blk_raw < 16) return 16;
      if (blk_raw > md_pad_pkg::MAX_BLOCK_WORDS) return md_pad_pkg::MAX_BLOCK_WORDS;
      return int'(blk_raw);
   endfunction

   function int lenw();
      if (len_raw < 2) return 2;
      if (len_raw > md_pad_pkg::MAX_LENGTH_WORDS) return md_pad_pkg::MAX_LENGTH_WORDS;
      return int'(len_raw);
   endfunction

   function bit [31:0] arrange(bit [31:0] seq);
      if (big_end) return seq;
      return {seq[7:0], seq[15:8], seq[23:16], seq[31:24]};
   endfunction

   function bit [31:0] length_part(int k);
      bit [63:0] v;
      v = ((k >> 1) & 1) ? bits_hi : bits_lo;
      return (k & 1) ? v[63:32] : v[31:0];
   endfunction

   function void push_word(bit [31:0] w, bit fin);
      pad_word_type r;
      bit        last;
      last = (int'(pos) + 1 >= blk());
      r.word = w;
      r.word_index = pos;
      r.block_end = last;
      r.padded_end = fin;
      r.last_in_run = 1'b0;
      pending_words.push_back(r);
      pos = last ? 5'd0 : pos + 5'd1;
   endfunction

   function void note_item(bit [7:0] b, bit msg_end);
      int        before_cnt;
      int        bw;
      int        lw;
      int        k;
      bit [31:0] seq;
      pad_word_type tail;
      before_cnt = pending_words.size();
      lw = lenw();
      if (!msg_end) begin
         bits_lo += 64'd8;
         if (bits_lo < 64'd8) bits_hi += 64'd1;
         if (lw <= 2) bits_hi = '0;
         else if (lw == 3) bits_hi &= 64'hFFFF_FFFF;
         if (held_cnt == 2'd3) begin
            push_word(arrange({held, b}), 1'b0);
            held = '0;
            held_cnt = '0;
         end else begin
            held = {held[15:0], b};
            held_cnt++;
         end
      end else begin
         bw = blk();
         seq = {held, 8'h80};
         seq = seq << (8 * (3 - int'(held_cnt)));
         push_word(arrange(seq), 1'b0);
         while (int'(pos) != bw - lw) push_word('0, 1'b0);
         for (k = 0; k < lw; k++)
            push_word(length_part(big_end ? lw - 1 - k : k), k + 1 == lw);
         clear_message();
      end
      if (pending_words.size() > before_cnt) begin
         tail = pending_words.pop_back();
         tail.last_in_run = 1'b1;
         pending_words.push_back(tail);
      end
   endfunction

   function void check_word(pad_word_type got);
      pad_word_type want;
      words_checked++;
      if (pending_words.size() == 0) begin
         $error("unexpected word %h at index %0d", got.word, got.word_index);
         errors++;
         return;
      end
      want = pending_words.pop_front();
      if (got.word !== want.word) begin
         $error("word expected %h actual %h", want.word, got.word);
         errors++;
      end
      if (got.word_index !== want.word_index) begin
         $error("word_index expected %0d actual %0d", want.word_index, got.word_index);
         errors++;
      end
      if (got.block_end !== want.block_end) begin
         $error("block_end expected %0b actual %0b", want.block_end, got.block_end);
         errors++;
      end
      if (got.padded_end !== want.padded_end) begin
         $error("padded_end expected %0b actual %0b", want.padded_end, got.padded_end);
         errors++;
      end
      if (got.last_in_run !== want.last_in_run) begin
         $error("last_in_run expected %0b actual %0b", want.last_in_run, got.last_in_run);
         errors++;
      end
   endfunction
endclass

module md_message_padder_top_tb;

   localparam logic [1:0] CSR_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        req_message_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_word;
   logic [4:0]  rsp_word_index;
   logic        rsp_block_end;
   logic        rsp_padded_end;
   logic        rsp_last_in_run;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [5:0]  csr_wdata = '0;

   md_pad_scoreboard sb = new();

   int send_idle_pct = 0;
   int stall_pct = 0;
   int items_sent = 0;
   int msgs_sent = 0;
   int settings_used = 1;
   int csr_writes = 0;
   int bytes_left = 0;

   md_message_padder_top DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_message_end (req_message_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_word        (rsp_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_block_end   (rsp_block_end),
      .rsp_padded_end  (rsp_padded_end),
      .rsp_last_in_run (rsp_last_in_run),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_word({rsp_word, rsp_word_index, rsp_block_end, rsp_padded_end,
                        rsp_last_in_run});
      rsp_ready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   initial begin
      #20_000_000;
      $display("FAIL md_message_padder_top");
      $finish;
   end

   task automatic send_item(input logic [7:0] b, input logic msg_end);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_message_end <= msg_end;
      do @(posedge clock); while (!req_ready);
      sb.note_item(b, msg_end);
      items_sent++;
      if (msg_end) msgs_sent++;
   endtask

   // sender holds off until every word has come out
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [5:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
      csr_writes++;
   endtask

   task automatic configure(input logic be, input logic [5:0] bw, input logic [2:0] lw,
                            input int mode);
      settle();
      write_csr(md_pad_pkg::CSR_BIG_ENDIAN, {5'($urandom), be});
      write_csr(md_pad_pkg::CSR_BLOCK_WORDS, bw);
      write_csr(md_pad_pkg::CSR_LENGTH_WORDS, {3'($urandom), lw});
      write_csr(CSR_UNUSED, 6'($urandom));
      csr_wr_en <= 1'b0;
      @(posedge clock);
      settings_used++;
      case (mode)
         1:       begin send_idle_pct = 63; stall_pct = 0;  end
         2:       begin send_idle_pct = 0;  stall_pct = 63; end
         3:       begin send_idle_pct = 28; stall_pct = 28; end
         default: begin send_idle_pct = 0;  stall_pct = 0;  end
      endcase
   endtask

   task automatic send_bytes(input logic [7:0] b0, input logic [7:0] b1,
                             input logic [7:0] b2, input logic [7:0] b3, input int n);
      logic [7:0] seq [4];
      int         i;
      seq = '{b0, b1, b2, b3};
      for (i = 0; i < n; i++) send_item(seq[i], 1'b0);
      send_item(8'($urandom), 1'b1);
   endtask

   // messages run across phase ends, so settings also change mid message
   task automatic run_messages(input int budget);
      int sent;
      int r;
      int len;
      sent = 0;
      while (sent < budget) begin
         if (bytes_left == 0) begin
            r = $urandom_range(99);
            if (r < 50)      len = $urandom_range(6);
            else if (r < 75) len = $urandom_range(40, 7);
            else if (r < 90) len = 4 * (sb.blk() - sb.lenw()) + $urandom_range(11) - 4;
            else             len = $urandom_range(135, 41);
            bytes_left = len + 1;
         end
         bytes_left--;
         send_item(8'($urandom), bytes_left == 0);
         sent++;
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings, big endian
      send_item(8'hFF, 1'b1);
      send_bytes(8'hFF, 8'h00, 8'h80, 8'h00, 3);
      send_bytes(8'h01, 8'h00, 8'h00, 8'h00, 1);
      send_bytes(8'h7F, 8'hFE, 8'h00, 8'h00, 2);
      send_bytes(8'hAA, 8'h55, 8'hCC, 8'h33, 4);

      configure(1'b0, 6'd16, 3'd2, 0);
      send_bytes(8'h12, 8'h34, 8'h56, 8'h00, 3);
      send_bytes(8'h9A, 8'hBC, 8'hDE, 8'hF0, 4);

      configure(1'b0, 6'd32, 3'd4, 0);
      run_messages(48);
      configure(1'b1, 6'd32, 3'd3, 1);
      run_messages(24);
      settle();
      run_messages(24);
      configure(1'b0, 6'd16, 3'd2, 2);
      run_messages(48);
      configure(1'b1, 6'd0, 3'd0, 3);
      run_messages(48);
      configure(1'b0, 6'd63, 3'd7, 1);
      run_messages(48);
      configure(1'($urandom), 6'($urandom_range(32, 16)), 3'($urandom_range(4, 2)), 2);
      run_messages(48);
      configure(1'($urandom), 6'($urandom), 3'($urandom), 3);
      run_messages(48);
      configure(1'b1, 6'd16, 3'd2, 0);
      run_messages(48);
      if (bytes_left != 0) begin
         bytes_left = 0;
         send_item(8'($urandom), 1'b1);
      end

      settle();
      repeat (20) @(posedge clock);
      if (sb.pending_words.size() != 0) begin
         $error("%0d words never came out", sb.pending_words.size());
         sb.errors++;
      end
      $display("covered %0d items in %0d messages, %0d words checked", items_sent, msgs_sent,
               sb.words_checked);
      $display("%0d register writes over %0d settings incl. saturated sizes, four idle modes",
               csr_writes, settings_used);
      if (sb.errors == 0) begin
         $display("PASS md_message_padder_top");
      end else begin
         $display("FAIL md_message_padder_top");
      end
      $finish;
   end

endmodule
